[src/fp32_special_case_filter_top_macros.svh]
// Assertion macros used by the special-case filter top level.
`ifndef FP32_SPECIAL_CASE_FILTER_TOP_MACROS_SVH
`define FP32_SPECIAL_CASE_FILTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FP32SCF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FP32SCF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/fp32scf_pkg.sv]
// Types, operation codes and binary32 constants of the special-case filter.
package fp32scf_pkg;

   localparam int CMD_W = 4;

   localparam logic [CMD_W-1:0] CMD_EXP2    = 4'd0;
   localparam logic [CMD_W-1:0] CMD_LOG2    = 4'd1;
   localparam logic [CMD_W-1:0] CMD_RCP     = 4'd2;
   localparam logic [CMD_W-1:0] CMD_SQRT    = 4'd3;
   localparam logic [CMD_W-1:0] CMD_RSQRT   = 4'd4;
   localparam logic [CMD_W-1:0] CMD_SIN     = 4'd5;
   localparam logic [CMD_W-1:0] CMD_COS     = 4'd6;
   localparam logic [CMD_W-1:0] CMD_SIGMOID = 4'd7;
   localparam logic [CMD_W-1:0] CMD_TANH    = 4'd8;
   localparam logic [CMD_W-1:0] CMD_EXP     = 4'd9;

   localparam logic [31:0] QNAN_OUT = 32'h7FFF_FFFF;
   localparam logic [31:0] POS_INF  = 32'h7F80_0000;
   localparam logic [31:0] NEG_INF  = 32'hFF80_0000;
   localparam logic [31:0] POS_ONE  = 32'h3F80_0000;
   localparam logic [31:0] NEG_ONE  = 32'hBF80_0000;
   localparam logic [31:0] HALF     = 32'h3F00_0000;
   localparam logic [31:0] POS_ZERO = 32'h0000_0000;
   localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
   localparam logic [30:0] EIGHT_MAG   = 31'h4100_0000;
   localparam logic [30:0] SIXTEEN_MAG = 31'h4180_0000;

   localparam logic [7:0]  EXP_BIAS = 8'd127;
   localparam logic [7:0]  EXP_MAX  = 8'hFF;
   // exp2 saturates once |x| >= 128, i.e. biased exponent >= bias + 7.
   localparam logic [7:0]  EXP2_SAT_EXP = EXP_BIAS + 8'd7;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [31:0]      value_bits;
   } req_type;

   typedef struct packed {
      logic        bypass_taken;
      logic [31:0] bypass_result;
      logic        operand_sign;
      logic [7:0]  operand_exponent;
      logic [22:0] operand_fraction;
   } rsp_type;

endpackage

[src/fp32scf_classify.sv]
// Operand unpacking, special-value detection and bypass result selection.
module fp32scf_classify (
   input  fp32scf_pkg::req_type req,
   output fp32scf_pkg::rsp_type rsp
);

   logic        sgn;
   logic [7:0]  expo;
   logic [22:0] frac;
   logic [30:0] mag;
   logic        is_nan;
   logic        is_inf;
   logic        is_zero;
   logic        by;
   logic [31:0] res;

   assign sgn     = req.value_bits[31];
   assign expo    = req.value_bits[30:23];
   assign frac    = req.value_bits[22:0];
   assign mag     = req.value_bits[30:0];
   assign is_nan  = (expo == fp32scf_pkg::EXP_MAX) && (frac != 23'd0);
   assign is_inf  = (expo == fp32scf_pkg::EXP_MAX) && (frac == 23'd0);
   assign is_zero = (expo == 8'd0) && (frac == 23'd0);

   always_comb begin
      by  = 1'b0;
      res = fp32scf_pkg::POS_ZERO;
      if (is_nan) begin
         by  = 1'b1;
         res = fp32scf_pkg::QNAN_OUT;
      end else begin
         case (req.command)
            fp32scf_pkg::CMD_EXP2: begin
               if (is_inf || (expo >= fp32scf_pkg::EXP2_SAT_EXP)) begin
                  by  = 1'b1;
                  res = sgn ? fp32scf_pkg::POS_ZERO : fp32scf_pkg::POS_INF;
               end else if (is_zero) begin
                  by  = 1'b1;
                  res = fp32scf_pkg::POS_ONE;
               end
            end
            fp32scf_pkg::CMD_LOG2: begin
               if (sgn && !is_zero) begin
                  by  = 1'b1;
                  res = fp32scf_pkg::QNAN_OUT;
               end else if (is_zero) begin
                  by  = 1'b1;
                  res = fp32scf_pkg::NEG_INF;
               end else if (is_inf) begin
                  by  = 1'b1;
                  res = fp32scf_pkg::POS_INF;
               end
            end
            fp32scf_pkg::CMD_RCP: begin
               if (is_zero) begin
                  by  = 1'b1;
                  res = sgn ? fp32scf_pkg::NEG_INF : fp32scf_pkg::POS_INF;
               end else if (is_inf) begin
                  by  = 1'b1;
                  res = sgn ? fp32scf_pkg::NEG_ZERO : fp32scf_pkg::POS_ZERO;
               end
            end
            fp32scf_pkg::CMD_SQRT: begin
               if (sgn && !is_zero) begin
                  by  = 1'b1;
                  res = fp32scf_pkg::QNAN_OUT;
               end else if (is_zero || is_inf) begin
                  by  = 1'b1;
                  res = req.value_bits;
               end
            end
            fp32scf_pkg::CMD_RSQRT: begin
               if (sgn && !is_zero) begin
                  by  = 1'b1;
                  res = fp32scf_pkg::QNAN_OUT;
               end else if (is_zero) begin
                  by  = 1'b1;
                  res = sgn ? fp32scf_pkg::NEG_INF : fp32scf_pkg::POS_INF;
               end else if (is_inf) begin
                  by  = 1'b1;
                  res = fp32scf_pkg::POS_ZERO;
               end
            end
            fp32scf_pkg::CMD_SIN: begin
               if (is_inf) begin
                  by  = 1'b1;
                  res = fp32scf_pkg::QNAN_OUT;
               end else if (is_zero) begin
                  by  = 1'b1;
                  res = req.value_bits;
               end
            end
            fp32scf_pkg::CMD_COS: begin
               if (is_inf) begin
                  by  = 1'b1;
                  res = fp32scf_pkg::QNAN_OUT;
               end else if (is_zero) begin
                  by  = 1'b1;
                  res = fp32scf_pkg::POS_ONE;
               end
            end
            fp32scf_pkg::CMD_SIGMOID: begin
               if (is_inf || (mag >= fp32scf_pkg::EIGHT_MAG)) begin
                  by  = 1'b1;
                  res = sgn ? fp32scf_pkg::POS_ZERO : fp32scf_pkg::POS_ONE;
               end else if (expo == 8'd0) begin
                  by  = 1'b1;
                  res = fp32scf_pkg::HALF;
               end
            end
            fp32scf_pkg::CMD_TANH: begin
               if (is_inf || (mag >= fp32scf_pkg::EIGHT_MAG)) begin
                  by  = 1'b1;
                  res = sgn ? fp32scf_pkg::NEG_ONE : fp32scf_pkg::POS_ONE;
               end else if (is_zero) begin
                  by  = 1'b1;
                  res = req.value_bits;
               end
            end
            fp32scf_pkg::CMD_EXP: begin
               if (is_inf) begin
                  by  = 1'b1;
                  res = sgn ? fp32scf_pkg::POS_ZERO : fp32scf_pkg::POS_ONE;
               end else if ((expo == 8'd0) || !sgn) begin
                  by  = 1'b1;
                  res = fp32scf_pkg::POS_ONE;
               end else if (mag > fp32scf_pkg::SIXTEEN_MAG) begin
                  by  = 1'b1;
                  res = fp32scf_pkg::POS_ZERO;
               end
            end
            default: begin
               by  = 1'b0;
               res = fp32scf_pkg::POS_ZERO;
            end
         endcase
      end
   end

   assign rsp.bypass_taken     = by;
   assign rsp.bypass_result    = res;
   assign rsp.operand_sign     = sgn;
   assign rsp.operand_exponent = expo;
   assign rsp.operand_fraction = frac;

endmodule

[src/fp32_special_case_filter_top.sv]
// Top level of the binary32 special-case filter: input register, classifier, result register.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_ready  req_payload (command, value_bits)
//   rsp_      out        rsp_valid/rsp_ready  rsp_payload (bypass and unpacked fields)
//
// A req_ transaction passes through the input register, then the result register, to rsp_.
// One transaction per cycle while rsp_ready is high; the classifier sits between two registers.
// Reset (synchronous, active high) clears both valid flags; payload registers are not reset.
// When rsp_ready is low the result register holds, and the input register keeps accepting
// until it is also full, so a stall reaches req_ready only with both stages occupied.
`include "fp32_special_case_filter_top_macros.svh"

module fp32_special_case_filter_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fp32scf_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fp32scf_pkg::rsp_type rsp_payload
);

   // Input stage: holds the accepted operand and command.
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   fp32scf_pkg::req_type s1_data_ff;

   // Result stage: holds the finished result until the consumer takes it.
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   fp32scf_pkg::rsp_type rsp_data_ff;
   fp32scf_pkg::rsp_type rsp_data_in;

   logic                 out_free;
   logic                 s1_free;
   logic                 req_take;
   logic                 s1_move;

   // The result register can load when it is empty or is being emptied this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;
   // The input register can load when it is empty or its content moves on.
   assign s1_free  = !s1_valid_ff || out_free;
   assign s1_move  = s1_valid_ff && out_free;
   assign req_take = req_valid && s1_free;

   assign req_ready = s1_free;

   fp32scf_classify u_classify (
      .req (s1_data_ff),
      .rsp (rsp_data_in)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_free) begin
         s1_valid_in = req_valid;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_payload;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // A NaN operand always produces the canonical quiet NaN bypass.
   `FP32SCF_ASSERT_NEXT(a_nan_bypass,
      s1_move && (s1_data_ff.value_bits[30:23] == fp32scf_pkg::EXP_MAX)
         && (s1_data_ff.value_bits[22:0] != 23'd0),
      rsp_payload.bypass_taken && (rsp_payload.bypass_result == fp32scf_pkg::QNAN_OUT),
      "NaN operand did not give the quiet NaN bypass")

   // Without a bypass the result field must read as zero.
   `FP32SCF_ASSERT_SAME(a_no_bypass_zero,
      rsp_valid_ff && !rsp_payload.bypass_taken,
      rsp_payload.bypass_result == fp32scf_pkg::POS_ZERO,
      "bypass_result nonzero without a bypass")

   // Unpacked fields carry the operand bits of the transaction that moved.
   `FP32SCF_ASSERT_NEXT(a_unpack_match,
      s1_move,
      {rsp_payload.operand_sign, rsp_payload.operand_exponent,
         rsp_payload.operand_fraction} == $past(s1_data_ff.value_bits),
      "unpacked operand fields do not match the operand")

   // Undefined commands never bypass a non-NaN operand.
   `FP32SCF_ASSERT_NEXT(a_undef_cmd,
      s1_move && (s1_data_ff.command > fp32scf_pkg::CMD_EXP)
         && (s1_data_ff.value_bits[30:23] != fp32scf_pkg::EXP_MAX),
      !rsp_payload.bypass_taken,
      "undefined command produced a bypass")

   // A new transaction may enter a full input stage only while that stage drains.
   `FP32SCF_ASSERT_SAME(a_no_overwrite,
      req_take && s1_valid_ff,
      out_free,
      "input stage overwritten while its result could not move")

endmodule
